/* rtl/two_minus_erfc_approx_macros.svh */
// assertion macros for the two_minus_erfc_approx block
`ifndef TWO_MINUS_ERFC_APPROX_MACROS_SVH
`define TWO_MINUS_ERFC_APPROX_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define TMEA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("tmea assertion failed");
// next-cycle implication
`define TMEA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("tmea assertion failed");
`else
`define TMEA_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define TMEA_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

/* rtl/tmea_pkg.sv */
// widths, step counts and fixed-point constants of the 2-erfc pipeline
package tmea_pkg;

    localparam int XW           = 16;  // input argument
    localparam int RW           = 17;  // result
    localparam int OUT_TDATA_W  = 24;
    localparam int ZW           = 16;  // |x|
    localparam int DW           = 16;  // 8192 + |x|
    localparam int TW           = 31;  // t in q30, up to 2^30
    localparam int PW           = 34;  // signed horner value
    localparam int ZSQW         = 31;  // z*z, up to 2^30
    localparam int YW           = 37;  // negated exponent
    localparam int KW           = 8;   // power-of-two count
    localparam int LW           = 30;  // ln2 and reduced argument
    localparam int AW           = 31;  // taylor accumulator

    localparam int DIV_STEPS     = 31;
    localparam int HORNER_STEPS  = 9;
    localparam int TAYLOR_TERMS  = 10;
    localparam int EXP_K_MAX     = 40;
    localparam int RECIP_SH      = 31;

    // k estimate: (y >> KEST_SH) * KRECIP >> KREC_SH, low by at most one
    localparam int KEST_SH       = 22;
    localparam int KREC_SH       = 16;
    localparam int KRW           = 9;

    localparam longint Q30_SCALE = 64'sd1073741824;
    localparam longint DEC_SCALE = 64'sd1000000000;
    localparam longint HALF_DEC  = 64'sd500000000;

    localparam longint C0_Q = (64'sd1265512230 * Q30_SCALE + HALF_DEC) / DEC_SCALE;
    localparam longint C1_Q = (64'sd1000023680 * Q30_SCALE + HALF_DEC) / DEC_SCALE;
    localparam longint C2_Q = (64'sd374091960 * Q30_SCALE + HALF_DEC) / DEC_SCALE;
    localparam longint C3_Q = (64'sd96784180 * Q30_SCALE + HALF_DEC) / DEC_SCALE;
    localparam longint C4_Q = (64'sd186288060 * Q30_SCALE + HALF_DEC) / DEC_SCALE;
    localparam longint C5_Q = (64'sd278868070 * Q30_SCALE + HALF_DEC) / DEC_SCALE;
    localparam longint C6_Q = (64'sd1135203980 * Q30_SCALE + HALF_DEC) / DEC_SCALE;
    localparam longint C7_Q = (64'sd1488515870 * Q30_SCALE + HALF_DEC) / DEC_SCALE;
    localparam longint C8_Q = (64'sd822152230 * Q30_SCALE + HALF_DEC) / DEC_SCALE;
    localparam longint C9_Q = (64'sd170872770 * Q30_SCALE + HALF_DEC) / DEC_SCALE;
    localparam longint LN2_Q = (64'sd693147181 * Q30_SCALE + HALF_DEC) / DEC_SCALE;

    localparam logic signed [PW-1:0] COEF [0:9] = '{
        PW'(-C0_Q), PW'(C1_Q), PW'(C2_Q), PW'(C3_Q), PW'(-C4_Q),
        PW'(C5_Q), PW'(-C6_Q), PW'(C7_Q), PW'(-C8_Q), PW'(C9_Q)
    };

    localparam logic [LW-1:0] LN2 = LW'(LN2_Q);

    // floor(2^38 / ln2 in q30)
    localparam logic [KRW-1:0] KRECIP = KRW'((64'sd1 <<< 38) / LN2_Q);

    // floor(2^31 / n) for n = 1..10
    localparam logic [31:0] RECIP [0:9] = '{
        32'((64'd2147483648) / 64'd1), 32'((64'd2147483648) / 64'd2),
        32'((64'd2147483648) / 64'd3), 32'((64'd2147483648) / 64'd4),
        32'((64'd2147483648) / 64'd5), 32'((64'd2147483648) / 64'd6),
        32'((64'd2147483648) / 64'd7), 32'((64'd2147483648) / 64'd8),
        32'((64'd2147483648) / 64'd9), 32'((64'd2147483648) / 64'd10)
    };

    localparam logic [DW-1:0] DEN_BASE     = 16'd8192;
    localparam logic [DW-1:0] DIV_REM_INIT = 16'd4096;  // 2^43 + den/2, bits 43..31
    localparam logic [AW-1:0] ONE_ACC      = 31'd1073741824;
    localparam logic [TW-1:0] T_MAX        = 31'd1073741824;
    localparam logic [TW-1:0] T_MIN        = TW'((64'd8796093022208 + 64'd20480) / 64'd40960);
    localparam logic [RW-1:0] RES_MAX      = 17'd65536;

endpackage

/* rtl/two_minus_erfc_approx.sv */
// 2 - erfc(x) in fixed point: one fully pipelined datapath
// throughput: one beat per cycle; a stall at the output freezes the whole pipe
// stages: 32 reciprocal stages, 19 horner stages, 4 range-reduction stages,
//   31 taylor stages, then exp shift, t multiply and rounding/clamp
// reset: i_rst_n synchronous active low, clears all valid bits; payload is not reset
`include "two_minus_erfc_approx_macros.svh"

module two_minus_erfc_approx (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    input  logic [tmea_pkg::XW-1:0]              i_s_axis_tdata,  // [15:0] x_value
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    output logic [tmea_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata   // [16:0] result_value
);

    localparam int DS = tmea_pkg::DIV_STEPS;
    localparam int HS = tmea_pkg::HORNER_STEPS;
    localparam int TS = tmea_pkg::TAYLOR_TERMS;
    localparam int DW = tmea_pkg::DW;
    localparam int TW = tmea_pkg::TW;
    localparam int PW = tmea_pkg::PW;
    localparam int YW = tmea_pkg::YW;
    localparam int KW = tmea_pkg::KW;
    localparam int LW = tmea_pkg::LW;
    localparam int AW = tmea_pkg::AW;
    localparam int ZW = tmea_pkg::ZW;
    localparam int ZSQW = tmea_pkg::ZSQW;
    localparam int RW = tmea_pkg::RW;

    // global advance: the pipe moves unless a finished beat waits at the output
    logic w_adv;
    logic r_out_valid;
    logic [RW-1:0] r_out_res;

    assign w_adv           = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = w_adv;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(tmea_pkg::OUT_TDATA_W-RW){1'b0}}, r_out_res};

    // ------------------------------------------------------------------
    // input stage: z = |x|, den = 8192 + z, seed the reciprocal divider
    // t = round(2^43 / den) by restoring division, one quotient bit a stage
    // ------------------------------------------------------------------
    logic [DS:0]     r_dv_valid;
    logic            r_dv_neg [0:DS];
    logic [ZW-1:0]   r_dv_z   [0:DS];
    logic [DW-1:0]   r_dv_den [0:DS];
    logic [DW-1:0]   r_dv_rem [0:DS];
    logic [TW-1:0]   r_dv_q   [0:DS];

    logic            n_in_neg;
    logic [ZW-1:0]   n_in_z;

    assign n_in_neg = i_s_axis_tdata[tmea_pkg::XW-1];
    assign n_in_z   = n_in_neg ? (ZW'(0) - i_s_axis_tdata) : i_s_axis_tdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_valid[0] <= 1'b0;
        end else if (w_adv) begin
            r_dv_valid[0] <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dv_neg[0] <= n_in_neg;
            r_dv_z[0]   <= n_in_z;
            r_dv_den[0] <= tmea_pkg::DEN_BASE + n_in_z;
            r_dv_rem[0] <= tmea_pkg::DIV_REM_INIT;
            r_dv_q[0]   <= '0;
        end
    end

    for (genvar j = 0; j < DS; j++) begin : g_div
        // numerator bits below 31 are den >> 1
        localparam int BI = DS - 1 - j;
        logic          n_nb;
        logic [DW:0]   n_sh;
        logic          n_ge;

        if (BI < DW - 1) begin : g_nb
            assign n_nb = r_dv_den[j][BI+1];
        end else begin : g_nz
            assign n_nb = 1'b0;
        end

        assign n_sh = {r_dv_rem[j], n_nb};
        assign n_ge = n_sh >= {1'b0, r_dv_den[j]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_valid[j+1] <= 1'b0;
            end else if (w_adv) begin
                r_dv_valid[j+1] <= r_dv_valid[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_dv_neg[j+1] <= r_dv_neg[j];
                r_dv_z[j+1]   <= r_dv_z[j];
                r_dv_den[j+1] <= r_dv_den[j];
                r_dv_rem[j+1] <= n_ge ? DW'(n_sh - {1'b0, r_dv_den[j]}) : n_sh[DW-1:0];
                r_dv_q[j+1]   <= {r_dv_q[j][TW-2:0], n_ge};
            end
        end
    end

    // ------------------------------------------------------------------
    // horner: p = c + t*p, each step a multiply stage and a round/add stage
    // z*z is formed on entry and carried along
    // ------------------------------------------------------------------
    logic [HS:0]             r_ha_valid;
    logic                    r_ha_neg [0:HS];
    logic [TW-1:0]           r_ha_t   [0:HS];
    logic [ZSQW-1:0]         r_ha_zsq [0:HS];
    logic signed [PW-1:0]    r_ha_p   [0:HS];

    logic [HS-1:0]           r_hm_valid;
    logic                    r_hm_neg  [0:HS-1];
    logic [TW-1:0]           r_hm_t    [0:HS-1];
    logic [ZSQW-1:0]         r_hm_zsq  [0:HS-1];
    logic                    r_hm_sgn  [0:HS-1];
    logic [63:0]             r_hm_prod [0:HS-1];

    logic [2*ZW-1:0]         n_zsq;
    assign n_zsq = r_dv_z[DS] * r_dv_z[DS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ha_valid[0] <= 1'b0;
        end else if (w_adv) begin
            r_ha_valid[0] <= r_dv_valid[DS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_ha_neg[0] <= r_dv_neg[DS];
            r_ha_t[0]   <= r_dv_q[DS];
            r_ha_zsq[0] <= n_zsq[ZSQW-1:0];
            r_ha_p[0]   <= tmea_pkg::COEF[9];
        end
    end

    for (genvar h = 0; h < HS; h++) begin : g_horner
        logic            n_sgn;
        logic [PW-2:0]   n_mag;
        logic [63:0]     n_rsum;
        logic [PW-2:0]   n_rnd;
        logic signed [PW-1:0] n_sp;

        // sign-magnitude multiply, rounds half away from zero
        assign n_sgn = r_ha_p[h][PW-1];
        assign n_mag = n_sgn ? (PW-1)'(-r_ha_p[h]) : (PW-1)'(r_ha_p[h]);

        assign n_rsum = r_hm_prod[h] + 64'd536870912;
        assign n_rnd  = n_rsum[PW-2+30:30];
        assign n_sp   = r_hm_sgn[h] ? -$signed({1'b0, n_rnd}) : $signed({1'b0, n_rnd});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_hm_valid[h]   <= 1'b0;
                r_ha_valid[h+1] <= 1'b0;
            end else if (w_adv) begin
                r_hm_valid[h]   <= r_ha_valid[h];
                r_ha_valid[h+1] <= r_hm_valid[h];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_hm_neg[h]  <= r_ha_neg[h];
                r_hm_t[h]    <= r_ha_t[h];
                r_hm_zsq[h]  <= r_ha_zsq[h];
                r_hm_sgn[h]  <= n_sgn;
                r_hm_prod[h] <= n_mag * r_ha_t[h];

                r_ha_neg[h+1] <= r_hm_neg[h];
                r_ha_t[h+1]   <= r_hm_t[h];
                r_ha_zsq[h+1] <= r_hm_zsq[h];
                r_ha_p[h+1]   <= tmea_pkg::COEF[HS-1-h] + n_sp;
            end
        end
    end

    // ------------------------------------------------------------------
    // exponent e = p - z*z (q30); y = -e, positive exponent clamps to zero
    // then y = k*ln2 + r: k estimated from the top bits of y by a
    // reciprocal multiply, remainder by one multiply, one correction step
    // ------------------------------------------------------------------
    logic             r_ky_valid;
    logic             r_ky_neg;
    logic [TW-1:0]    r_ky_t;
    logic [YW-1:0]    r_ky_y;

    logic             r_kq_valid;
    logic             r_kq_neg;
    logic [TW-1:0]    r_kq_t;
    logic [YW-1:0]    r_kq_y;
    logic [KW-1:0]    r_kq_k;

    logic             r_kr_valid;
    logic             r_kr_neg;
    logic [TW-1:0]    r_kr_t;
    logic [LW:0]      r_kr_rem;
    logic [KW-1:0]    r_kr_k;

    logic             r_kd_valid;
    logic             r_kd_neg;
    logic [TW-1:0]    r_kd_t;
    logic [LW-1:0]    r_kd_rem;
    logic [KW-1:0]    r_kd_k;

    logic [YW:0]      n_e;
    logic [YW-tmea_pkg::KEST_SH+tmea_pkg::KRW-1:0] n_kprod;
    logic [KW-1:0]    n_kest;
    logic [KW+LW-1:0] n_kmul;
    logic             n_kfix;

    assign n_e = {{(YW+1-PW){r_ha_p[HS][PW-1]}}, r_ha_p[HS]} - {1'b0, r_ha_zsq[HS], 6'b0};

    // estimate is never high and at most one low
    assign n_kprod = r_ky_y[YW-1:tmea_pkg::KEST_SH] * tmea_pkg::KRECIP;
    assign n_kest  = n_kprod[tmea_pkg::KREC_SH+KW-1:tmea_pkg::KREC_SH];
    assign n_kmul  = r_kq_k * tmea_pkg::LN2;
    assign n_kfix  = r_kr_rem >= (LW+1)'(tmea_pkg::LN2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ky_valid <= 1'b0;
            r_kq_valid <= 1'b0;
            r_kr_valid <= 1'b0;
            r_kd_valid <= 1'b0;
        end else if (w_adv) begin
            r_ky_valid <= r_ha_valid[HS];
            r_kq_valid <= r_ky_valid;
            r_kr_valid <= r_kq_valid;
            r_kd_valid <= r_kr_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_ky_neg <= r_ha_neg[HS];
            r_ky_t   <= r_ha_t[HS];
            r_ky_y   <= n_e[YW] ? YW'(-n_e) : '0;

            r_kq_neg <= r_ky_neg;
            r_kq_t   <= r_ky_t;
            r_kq_y   <= r_ky_y;
            r_kq_k   <= n_kest;

            // remainder below 2*ln2 here
            r_kr_neg <= r_kq_neg;
            r_kr_t   <= r_kq_t;
            r_kr_rem <= (LW+1)'(r_kq_y - YW'(n_kmul));
            r_kr_k   <= r_kq_k;

            r_kd_neg <= r_kr_neg;
            r_kd_t   <= r_kr_t;
            r_kd_rem <= n_kfix ? LW'(r_kr_rem - (LW+1)'(tmea_pkg::LN2)) : r_kr_rem[LW-1:0];
            r_kd_k   <= r_kr_k + KW'(n_kfix);
        end
    end

    // ------------------------------------------------------------------
    // exp(-r): ten taylor terms in horner form, acc = 1 - round(r*acc)/n
    // each term: multiply, round and reciprocal multiply, quotient fix-up
    // ------------------------------------------------------------------
    logic [TS:0]      r_ta_valid;
    logic             r_ta_neg [0:TS];
    logic [TW-1:0]    r_ta_t   [0:TS];
    logic [LW-1:0]    r_ta_r   [0:TS];
    logic [KW-1:0]    r_ta_k   [0:TS];
    logic [AW-1:0]    r_ta_acc [0:TS];

    logic [TS-1:0]    r_tm_valid;
    logic             r_tm_neg  [0:TS-1];
    logic [TW-1:0]    r_tm_t    [0:TS-1];
    logic [LW-1:0]    r_tm_r    [0:TS-1];
    logic [KW-1:0]    r_tm_k    [0:TS-1];
    logic [LW+AW-1:0] r_tm_prod [0:TS-1];

    logic [TS-1:0]    r_tv_valid;
    logic             r_tv_neg [0:TS-1];
    logic [TW-1:0]    r_tv_t   [0:TS-1];
    logic [LW-1:0]    r_tv_r   [0:TS-1];
    logic [KW-1:0]    r_tv_k   [0:TS-1];
    logic [AW-1:0]    r_tv_v   [0:TS-1];
    logic [AW-1:0]    r_tv_qe  [0:TS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ta_valid[0] <= 1'b0;
        end else if (w_adv) begin
            r_ta_valid[0] <= r_kd_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_ta_neg[0] <= r_kd_neg;
            r_ta_t[0]   <= r_kd_t;
            r_ta_r[0]   <= r_kd_rem;
            r_ta_k[0]   <= r_kd_k;
            r_ta_acc[0] <= tmea_pkg::ONE_ACC;
        end
    end

    for (genvar j = 0; j < TS; j++) begin : g_taylor
        localparam int            N      = TS - j;
        localparam logic [AW-1:0] N_VAL  = AW'(N);
        localparam logic [AW-1:0] N_HALF = AW'(N / 2);
        logic [LW+AW:0]   n_psum;
        logic [AW-1:0]    n_v;
        logic [AW+31:0]   n_qm;
        logic [AW-1:0]    n_rem;
        logic [AW-1:0]    n_q;

        assign n_psum = {1'b0, r_tm_prod[j]} + (LW+AW+1)'(536870912);
        assign n_v    = n_psum[AW+29:30] + N_HALF;
        assign n_qm   = n_v * tmea_pkg::RECIP[N-1];

        // reciprocal estimate is low by at most one
        assign n_rem = r_tv_v[j] - AW'(r_tv_qe[j] * N_VAL);
        assign n_q   = r_tv_qe[j] + AW'(n_rem >= N_VAL);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tm_valid[j]   <= 1'b0;
                r_tv_valid[j]   <= 1'b0;
                r_ta_valid[j+1] <= 1'b0;
            end else if (w_adv) begin
                r_tm_valid[j]   <= r_ta_valid[j];
                r_tv_valid[j]   <= r_tm_valid[j];
                r_ta_valid[j+1] <= r_tv_valid[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_tm_neg[j]  <= r_ta_neg[j];
                r_tm_t[j]    <= r_ta_t[j];
                r_tm_r[j]    <= r_ta_r[j];
                r_tm_k[j]    <= r_ta_k[j];
                r_tm_prod[j] <= r_ta_r[j] * r_ta_acc[j];

                r_tv_neg[j] <= r_tm_neg[j];
                r_tv_t[j]   <= r_tm_t[j];
                r_tv_r[j]   <= r_tm_r[j];
                r_tv_k[j]   <= r_tm_k[j];
                r_tv_v[j]   <= n_v;
                r_tv_qe[j]  <= n_qm[AW+tmea_pkg::RECIP_SH-1:tmea_pkg::RECIP_SH];

                r_ta_neg[j+1] <= r_tv_neg[j];
                r_ta_t[j+1]   <= r_tv_t[j];
                r_ta_r[j+1]   <= r_tv_r[j];
                r_ta_k[j+1]   <= r_tv_k[j];
                r_ta_acc[j+1] <= tmea_pkg::ONE_ACC - n_q;
            end
        end
    end

    // ------------------------------------------------------------------
    // scale by 2^-k with rounding, underflow to zero past k = 40
    // ------------------------------------------------------------------
    logic             r_sh_valid;
    logic             r_sh_neg;
    logic [TW-1:0]    r_sh_t;
    logic [AW-1:0]    r_sh_ex;

    logic [AW:0]      n_sh_rb;
    logic [AW:0]      n_sh_sum;
    logic [AW-1:0]    n_sh_ex;

    always_comb begin
        n_sh_rb  = '0;
        n_sh_sum = '0;
        if (r_ta_k[TS] > KW'(tmea_pkg::EXP_K_MAX)) begin
            n_sh_ex = '0;
        end else if (r_ta_k[TS] == '0) begin
            n_sh_ex = r_ta_acc[TS];
        end else begin
            n_sh_rb  = (AW+1)'(1) << (r_ta_k[TS] - KW'(1));
            n_sh_sum = {1'b0, r_ta_acc[TS]} + n_sh_rb;
            n_sh_ex  = AW'(n_sh_sum >> r_ta_k[TS]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sh_valid <= 1'b0;
        end else if (w_adv) begin
            r_sh_valid <= r_ta_valid[TS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sh_neg <= r_ta_neg[TS];
            r_sh_t   <= r_ta_t[TS];
            r_sh_ex  <= n_sh_ex;
        end
    end

    // ------------------------------------------------------------------
    // ans = t * exp(e), then q15 rounding, clamp and sign branch
    // ------------------------------------------------------------------
    logic               r_am_valid;
    logic               r_am_neg;
    logic [TW+AW-1:0]   r_am_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_am_valid <= 1'b0;
        end else if (w_adv) begin
            r_am_valid <= r_sh_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_am_neg  <= r_sh_neg;
            r_am_prod <= r_sh_t * r_sh_ex;
        end
    end

    logic [TW+AW:0]   n_a30_sum;
    logic [32:0]      n_a15_sum;
    logic [RW-1:0]    n_a15;

    // t and exp are both at most one, so ans30 fits in 32 bits
    assign n_a30_sum = {1'b0, r_am_prod} + (TW+AW+1)'(536870912);
    assign n_a15_sum = {1'b0, n_a30_sum[TW+AW-1:30]} + 33'd16384;
    assign n_a15     = (n_a15_sum[32:15] > 18'(tmea_pkg::RES_MAX)) ? tmea_pkg::RES_MAX
                                                                     : n_a15_sum[RW+14:15];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_am_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_res <= r_am_neg ? n_a15 : (tmea_pkg::RES_MAX - n_a15);
        end
    end

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    logic w_t_ok;
    assign w_t_ok = (r_dv_q[DS] <= tmea_pkg::T_MAX) && (r_dv_q[DS] >= tmea_pkg::T_MIN);

    `TMEA_ASSERT_IMP(a_res_range, i_clk, i_rst_n, r_out_valid, r_out_res <= tmea_pkg::RES_MAX)
    `TMEA_ASSERT_IMP(a_recip_range, i_clk, i_rst_n, r_dv_valid[DS], w_t_ok)
    `TMEA_ASSERT_IMP(a_kred_rem, i_clk, i_rst_n, r_kd_valid, r_kd_rem < tmea_pkg::LN2)
    `TMEA_ASSERT_IMP(a_taylor_acc, i_clk, i_rst_n, r_ta_valid[TS], r_ta_acc[TS] <= tmea_pkg::ONE_ACC)
    `TMEA_ASSERT_NXT(a_stall_hold, i_clk, i_rst_n, !w_adv, $stable(r_dv_valid) && $stable(r_out_valid))

endmodule
